@@ rtl/rned_pkg.sv @@
// shared types and constants for the escape-coded run-length sprite decoder
// no dependencies; imported by every module under rtl/
package rned_pkg;

    localparam int DIM_BITS   = 16;
    localparam int TOTAL_BITS = 2 * DIM_BITS;
    localparam int DONE_BITS  = 32;
    localparam int BYTE_BITS  = 8;
    localparam int RUN_BITS   = 4;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [BYTE_BITS-1:0] ESC_LIMIT = 8'hF0;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 8'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EMIT
    } t_seq_state;

    // image size status handed from the dimension unit to the sequencer and counter
    typedef struct packed {
        logic                  busy;
        logic                  zero;
        logic [TOTAL_BITS-1:0] total_m1;
    } t_dim_status;

endpackage

@@ rtl/rned_dim_unit.sv @@
// image dimension registers and the registered width*height product
// depends on rned_pkg
module rned_dim_unit
    import rned_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_dim_status              o_status
);

    logic [CFG_DATA_BITS-1:0] r_width;
    logic [CFG_DATA_BITS-1:0] r_height;
    logic                     r_dirty;
    logic                     r_prod_vld;
    logic [TOTAL_BITS-1:0]    r_prod;
    logic [TOTAL_BITS-1:0]    r_total_m1;
    logic                     r_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= CFG_DATA_BITS'(1);
            r_height   <= CFG_DATA_BITS'(1);
            r_dirty    <= 1'b0;
            r_prod_vld <= 1'b0;
            r_total_m1 <= '0;
            r_zero     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_WIDTH) begin
                    r_width <= i_cfg_data;
                end else if (i_cfg_index == CFG_IDX_HEIGHT) begin
                    r_height <= i_cfg_data;
                end
            end
            r_dirty    <= i_cfg_we;
            r_prod_vld <= r_dirty;
            if (r_prod_vld) begin
                r_total_m1 <= r_prod - TOTAL_BITS'(1);
                r_zero     <= (r_prod == '0);
            end
        end
    end

    // only the low DIM_BITS of each dimension count
    always_ff @(posedge i_clk) begin
        r_prod <= TOTAL_BITS'(r_width[DIM_BITS-1:0]) * TOTAL_BITS'(r_height[DIM_BITS-1:0]);
    end

    assign o_status.busy     = i_cfg_we | r_dirty | r_prod_vld;
    assign o_status.zero     = r_zero;
    assign o_status.total_m1 = r_total_m1;

endmodule

@@ rtl/rned_pix_counter.sv @@
// pixel counter with the shared end-of-image compare and increment
// depends on rned_pkg
module rned_pix_counter
    import rned_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [TOTAL_BITS-1:0] i_total_m1,
    output logic                  o_last
);

    logic [DONE_BITS-1:0] r_done;
    logic [DONE_BITS-1:0] n_done;

    // count at or past total-1 means this pixel closes the image
    assign o_last = (r_done >= DONE_BITS'(i_total_m1));

    always_comb begin
        n_done = r_done;
        if (i_step) begin
            n_done = o_last ? '0 : r_done + DONE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= '0;
        end else begin
            r_done <= n_done;
        end
    end

endmodule

@@ rtl/rned_seq.sv @@
// byte parser and pixel emit sequencer with the output register
// depends on rned_pkg
module rned_seq
    import rned_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_BITS-1:0] i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_BITS-1:0] o_m_tdata,
    output logic                 o_m_tlast,
    input  t_dim_status          i_dim,
    input  logic                 i_last,
    output logic                 o_step
);

    t_seq_state           r_state, n_state;
    logic                 r_pending, n_pending;
    logic [RUN_BITS-1:0]  r_run_len, n_run_len;
    logic [RUN_BITS-1:0]  r_left, n_left;
    logic [BYTE_BITS-1:0] r_pix, n_pix;
    logic                 r_out_vld, n_out_vld;
    logic [BYTE_BITS-1:0] r_out_pix, n_out_pix;
    logic                 r_out_last, n_out_last;
    logic                 accept;
    logic                 out_free;

    assign o_s_tready = (r_state == ST_IDLE) && !i_dim.busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_vld || i_m_tready;

    always_comb begin
        n_state    = r_state;
        n_pending  = r_pending;
        n_run_len  = r_run_len;
        n_left     = r_left;
        n_pix      = r_pix;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_pix  = r_out_pix;
        n_out_last = r_out_last;
        o_step     = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_pix = i_s_tdata;
                    if (r_pending) begin
                        n_pending = 1'b0;
                        n_run_len = '0;
                        n_left    = r_run_len;
                        if (!i_dim.zero && r_run_len != '0) begin
                            n_state = ST_EMIT;
                        end
                    end else if (i_s_tdata > ESC_LIMIT) begin
                        n_pending = 1'b1;
                        n_run_len = i_s_tdata[RUN_BITS-1:0];
                    end else begin
                        n_left = RUN_BITS'(1);
                        if (!i_dim.zero) begin
                            n_state = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_step     = 1'b1;
                    n_out_vld  = 1'b1;
                    n_out_pix  = r_pix;
                    n_out_last = i_last;
                    n_left     = r_left - RUN_BITS'(1);
                    if (i_last || r_left == RUN_BITS'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pending <= 1'b0;
            r_run_len <= '0;
            r_left    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_run_len <= n_run_len;
            r_left    <= n_left;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_out_pix  <= n_out_pix;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_pix;
    assign o_m_tlast  = r_out_last;

endmodule

@@ rtl/rle_nibble_escape_decoder_unit.sv @@
// top level of the escape-coded run-length sprite decoder
// depends on rned_pkg, rned_dim_unit, rned_pix_counter, rned_seq
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------
//   s stream | in  | i_s_tvalid / o_s_tready | tdata[7:0] lump_byte
//   m stream | out | o_m_tvalid / i_m_tready | tdata[7:0] pixel_value,
//            |     |                         | tlast last_pixel
//   cfg      | in  | i_cfg_valid/o_cfg_ready | index 0 width, 1 height; data
//
// an escape byte is accepted and yields no pixel; a literal byte is accepted and
// then emits one pixel; a run data byte is accepted and then emits up to 15
// pixels, cut short at the image end by the single counter/compare unit
// the input is not ready while pixels of a byte are still being emitted
// a stalled output register holds the sequencer in its emit state
// after each register write the size product settles through r_dirty, r_prod_vld
// and r_total_m1, during which no byte is taken; reset is synchronous, active low
module rle_nibble_escape_decoder_unit
    import rned_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // slave stream
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [BYTE_BITS-1:0]     i_s_tdata,    // [7:0] lump_byte
    // master stream
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [BYTE_BITS-1:0]     o_m_tdata,    // [7:0] pixel_value
    output logic                     o_m_tlast,    // last_pixel
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_dim_status dim_status;
    logic        step;
    logic        last;

    // writes are always taken; index beyond the register list is dropped
    assign o_cfg_ready = 1'b1;

    rned_dim_unit u_dim (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (dim_status)
    );

    // shared compare/increment against width*height - 1
    rned_pix_counter u_cnt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_total_m1 (dim_status.total_m1),
        .o_last     (last)
    );

    rned_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_dim      (dim_status),
        .i_last     (last),
        .o_step     (step)
    );

endmodule

@@ sim/rle_decode_checker.sv @@
// pixel checker for the escape-coded run-length sprite decoder
// depends on rned_pkg; watches the cfg, s and m channels of the decoder
// and keeps its own decode state to predict every pixel beat
module rle_decode_checker
    import rned_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tready,
    input  logic [BYTE_BITS-1:0]     i_s_tdata,    // [7:0] lump_byte
    input  logic                     i_m_tvalid,
    input  logic                     i_m_tready,
    input  logic [BYTE_BITS-1:0]     i_m_tdata,    // [7:0] pixel_value
    input  logic                     i_m_tlast,    // last_pixel
    output int                       o_fail_count,
    output int                       o_pixels_pending
);

    typedef struct packed {
        logic [BYTE_BITS-1:0] value;
        logic                 last;
    } t_pixel;

    t_pixel               pixels_owed[$];
    logic [DIM_BITS-1:0]  img_width  = DIM_BITS'(1);
    logic [DIM_BITS-1:0]  img_height = DIM_BITS'(1);
    logic                 run_armed  = 1'b0;
    logic [RUN_BITS-1:0]  run_reps   = '0;
    logic [DONE_BITS-1:0] pix_done   = '0;
    int                   fails      = 0;

    // queue up to copies pixels, cut short at the last pixel of the image
    function automatic void emit_run(input logic [BYTE_BITS-1:0] value, input int copies);
        logic [DONE_BITS-1:0] total;
        t_pixel               pix;
        total = DONE_BITS'(img_width) * DONE_BITS'(img_height);
        if (total == '0)
            return;
        for (int k = 0; k < copies; k++) begin
            pix.value = value;
            pix.last  = (pix_done >= total - 1'b1);
            pixels_owed.push_back(pix);
            if (pix.last) begin
                pix_done = '0;
                break;
            end
            pix_done++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            img_width  = DIM_BITS'(1);
            img_height = DIM_BITS'(1);
            run_armed  = 1'b0;
            run_reps   = '0;
            pix_done   = '0;
            pixels_owed.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IDX_WIDTH:  img_width  = i_cfg_data[DIM_BITS-1:0];
                    CFG_IDX_HEIGHT: img_height = i_cfg_data[DIM_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                if (run_armed) begin
                    emit_run(i_s_tdata, int'(run_reps));
                    run_armed = 1'b0;
                    run_reps  = '0;
                end else if (i_s_tdata > ESC_LIMIT) begin
                    run_armed = 1'b1;
                    run_reps  = i_s_tdata[RUN_BITS-1:0];
                end else begin
                    emit_run(i_s_tdata, 1);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pixels_owed.size() == 0) begin
                    $error("pixel_value: expected no beat, got %02h (last %b)",
                           i_m_tdata, i_m_tlast);
                    fails++;
                end else begin
                    want = pixels_owed.pop_front();
                    if (i_m_tdata !== want.value) begin
                        $error("pixel_value: expected %02h, got %02h", want.value, i_m_tdata);
                        fails++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last_pixel: expected %b, got %b", want.last, i_m_tlast);
                        fails++;
                    end
                end
            end
        end
        o_fail_count     <= fails;
        o_pixels_pending <= pixels_owed.size();
    end

endmodule

@@ sim/rle_nibble_escape_decoder_unit_test.sv @@
// testbench top for the escape-coded run-length sprite decoder
// depends on rned_pkg, rle_nibble_escape_decoder_unit and rle_decode_checker;
// drives lump bytes and size writes, stalls the pixel side, gives the verdict
module rle_nibble_escape_decoder_unit_test;
    import rned_pkg::*;

    localparam int RANDOM_LUMPS  = 380;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    // cover the escape byte that yields no pixel and the size settling time
    localparam int SETTLE_CYCLES = 6;
    localparam int TAIL_CYCLES   = 20;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = CFG_IDX_HEIGHT + 1'b1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TOP   = {CFG_IDX_BITS{1'b1}};

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     s_tvalid    = 1'b0;
    logic [BYTE_BITS-1:0]     s_tdata     = '0;
    logic                     m_tready    = 1'b0;
    logic                     cfg_valid   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data    = '0;
    logic                     s_tready;
    logic                     m_tvalid;
    logic [BYTE_BITS-1:0]     m_tdata;
    logic                     m_tlast;
    logic                     cfg_ready;

    int fail_count;
    int pixels_pending;
    int cycle_count  = 0;
    int burst_left   = 0;
    int lumps_sent   = 0;
    // receiver hold-off request: bumped by the stimulus, served by the receiver
    int hold_token   = 0;
    int hold_seen    = 0;
    int hold_left    = 0;
    int rx_tick      = 0;

    always #5 i_clk = ~i_clk;

    rle_nibble_escape_decoder_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rle_decode_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_s_tvalid       (s_tvalid),
        .i_s_tready       (s_tready),
        .i_s_tdata        (s_tdata),
        .i_m_tvalid       (m_tvalid),
        .i_m_tready       (m_tready),
        .i_m_tdata        (m_tdata),
        .i_m_tlast        (m_tlast),
        .o_fail_count     (fail_count),
        .o_pixels_pending (pixels_pending)
    );

    // watchdog: a hung handshake or lost pixel ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("rle_nibble_escape_decoder_unit_test: FAIL");
            $finish;
        end
    end

    // pixel-side stall pattern: the mode follows rx_tick bits [8:6],
    // a pending hold-off request keeps tready low for a long stretch
    always @(posedge i_clk) begin
        rx_tick++;
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            case (rx_tick[8:6])
                3'd0, 3'd1: m_tready <= 1'b1;
                3'd2:       m_tready <= ($urandom_range(0, 3) != 0);
                3'd3:       m_tready <= ($urandom_range(0, 3) == 0);
                3'd4:       m_tready <= (rx_tick % 3 == 0);
                default:    m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // one lump beat; bursts of random length with random gaps in between
    task automatic send_lump(input logic [BYTE_BITS-1:0] lump);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 64 : 8);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= lump;
        do @(posedge i_clk); while (!s_tready);
        burst_left--;
        lumps_sent++;
    endtask

    // sender stays quiet until every predicted pixel has left the block
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pixels_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // leaves cfg_valid high so back-to-back writes never drop it in between
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // new image size, written only once the block is idle
    task automatic set_image(input logic [CFG_DATA_BITS-1:0] w,
                             input logic [CFG_DATA_BITS-1:0] h);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, w);
        write_reg(CFG_IDX_HEIGHT, h);
        // an unmapped index must not disturb anything
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_BITS'($urandom_range(CFG_IDX_SPARE, CFG_IDX_TOP)),
                      CFG_DATA_BITS'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [CFG_DATA_BITS-1:0] w;
        logic [CFG_DATA_BITS-1:0] h;
        int phase;
        int lumps_at_start;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset size is one pixel, so every pixel closes its own image
        send_lump(8'h00);
        send_lump(ESC_LIMIT);              // 0xF0 is a plain literal
        send_lump(8'hF3);                  // escape, run of three
        send_lump(8'hAB);                  // clipped to the single pixel

        // 5x3 image: short run, a run of 15 clipped at the image end,
        // an escape value used as run data
        set_image(16'd5, 16'd3);
        send_lump(8'hF1);
        send_lump(8'h55);
        send_lump(8'hFF);
        send_lump(8'hF5);
        send_lump(8'h7E);
        send_lump(8'hFF);
        send_lump(8'hFF);
        send_lump(8'h01);

        // zero width: bytes are parsed but nothing comes out;
        // the escape stays armed across the size change
        set_image(16'd0, 16'hFFFF);
        send_lump(8'h12);
        send_lump(8'hF4);
        set_image(16'hFFFF, 16'hFFFF);
        send_lump(8'h33);                  // run data for the armed escape
        send_lump(8'h80);
        send_lump(8'hF2);
        send_lump(8'hC9);

        // image shrunk below the count already done: next pixel ends it
        set_image(16'd1, 16'd2);
        send_lump(8'h9C);
        send_lump(8'h00);
        send_lump(8'h4D);

        // random phases: mostly small images, now and then extremes
        lumps_at_start = lumps_sent;
        phase = 0;
        while (lumps_sent - lumps_at_start < RANDOM_LUMPS) begin
            case ($urandom_range(0, 11))
                0: begin
                    w = '0;
                    h = CFG_DATA_BITS'($urandom);
                end
                1: begin
                    w = CFG_DATA_BITS'($urandom);
                    h = '0;
                end
                2: begin
                    w = '1;
                    h = '1;
                end
                3: begin
                    w = CFG_DATA_BITS'($urandom);
                    h = CFG_DATA_BITS'($urandom_range(1, 3));
                end
                default: begin
                    w = CFG_DATA_BITS'($urandom_range(1, 8));
                    h = CFG_DATA_BITS'($urandom_range(1, 8));
                end
            endcase
            set_image(w, h);
            // one long pixel-side hold-off while the sender keeps going
            if (phase == 2) begin
                w = 16'd4;
                h = 16'd4;
                set_image(w, h);
                hold_token++;
            end
            repeat ($urandom_range(15, 50)) begin
                case ($urandom_range(0, 9))
                    0: send_lump(BYTE_BITS'($urandom));        // noise, may leave a run armed
                    1, 2, 3: begin
                        send_lump(BYTE_BITS'($urandom_range(ESC_LIMIT + 1, 8'hFF)));
                        send_lump(BYTE_BITS'($urandom));
                    end
                    default: send_lump(BYTE_BITS'($urandom_range(0, ESC_LIMIT)));
                endcase
            end
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("rle_nibble_escape_decoder_unit_test: PASS");
        end else begin
            $display("rle_nibble_escape_decoder_unit_test: FAIL");
        end
        $finish;
    end

endmodule
